[design/maxwell_field_stencil_update_top_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the field stencil update block
// Same-cycle and next-cycle implication forms with async active-low reset.
// ----------------------------------------------------------------------------
`ifndef MAXWELL_FIELD_STENCIL_UPDATE_TOP_MACROS_SVH
`define MAXWELL_FIELD_STENCIL_UPDATE_TOP_MACROS_SVH

// same-cycle implication
`define MFSU_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("mfsu assertion failed");

// next-cycle implication
`define MFSU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("mfsu assertion failed");

`endif

[design/mfsu_pkg.sv]
// ----------------------------------------------------------------------------
// mfsu_pkg
// Shared types and constants of the field stencil update block.
// ----------------------------------------------------------------------------
package mfsu_pkg;

	localparam int CFG_IDX_W = 3;
	localparam int COEF_W    = 32;
	localparam int EDGE_W    = 6;

	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

	localparam cfg_idx_t CFG_GRID_EDGE    = 3'd0;
	localparam cfg_idx_t CFG_COEF_X       = 3'd1;
	localparam cfg_idx_t CFG_COEF_Y       = 3'd2;
	localparam cfg_idx_t CFG_COEF_Z       = 3'd3;
	localparam cfg_idx_t CFG_COEF_CURRENT = 3'd4;

	localparam logic [EDGE_W-1:0]        GRID_EDGE_RST    = 6'd32;
	localparam logic signed [COEF_W-1:0] COEF_AXIS_RST    = 32'sh0001_0000;
	localparam logic signed [COEF_W-1:0] COEF_CURRENT_RST = 32'sh0000_0000;

	// neighbor on a zero-index face: difference is zero
	typedef struct packed {
		logic first_i;
		logic first_j;
		logic first_k;
	} face_t;

endpackage

[design/mfsu_ram.sv]
// ----------------------------------------------------------------------------
// mfsu_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mfsu_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

[design/mfsu_calc.sv]
// ----------------------------------------------------------------------------
// mfsu_calc
// One-cell curl update: backward differences, coefficient products,
// exact sum, floor scale by 2^-16 and saturation.
// ----------------------------------------------------------------------------
module mfsu_calc #(
	parameter int VALUE_WIDTH = 32
) (
	input  logic signed [VALUE_WIDTH-1:0]      cur   [6],
	input  logic signed [VALUE_WIDTH-1:0]      jv    [3],
	input  logic signed [VALUE_WIDTH-1:0]      nbr_x [6],
	input  logic signed [VALUE_WIDTH-1:0]      nbr_y [6],
	input  logic signed [VALUE_WIDTH-1:0]      nbr_z [6],
	input  logic signed [mfsu_pkg::COEF_W-1:0] coef_x,
	input  logic signed [mfsu_pkg::COEF_W-1:0] coef_y,
	input  logic signed [mfsu_pkg::COEF_W-1:0] coef_z,
	input  logic signed [mfsu_pkg::COEF_W-1:0] coef_current,
	input  mfsu_pkg::face_t                    face,
	output logic signed [VALUE_WIDTH-1:0]      res   [6]
);

	localparam int VW  = VALUE_WIDTH;
	localparam int DW  = VW + 1;
	localparam int PRW = mfsu_pkg::COEF_W + DW;
	localparam int AW  = PRW + 2;
	localparam logic signed [AW-1:0] SAT_HI = AW'((64'sd1 <<< (VW - 1)) - 64'sd1);
	localparam logic signed [AW-1:0] SAT_LO = -SAT_HI - AW'(1);

	logic signed [VW-1:0] nx [6];
	logic signed [VW-1:0] ny [6];
	logic signed [VW-1:0] nz [6];
	logic signed [AW-1:0] acc [6];

	function automatic logic signed [PRW-1:0] term(
		input logic signed [mfsu_pkg::COEF_W-1:0] k,
		input logic signed [VW-1:0]               a,
		input logic signed [VW-1:0]               b
	);
		logic signed [DW-1:0] d;
		d = $signed({a[VW-1], a}) - $signed({b[VW-1], b});
		term = k * d;
	endfunction

	function automatic logic signed [AW-1:0] lift(input logic signed [VW-1:0] v);
		lift = AW'(v) <<< 16;
	endfunction

	function automatic logic signed [VW-1:0] finish(input logic signed [AW-1:0] s);
		logic signed [AW-1:0] sh;
		sh = s >>> 16;
		if (sh > SAT_HI) begin
			finish = SAT_HI[VW-1:0];
		end else if (sh < SAT_LO) begin
			finish = SAT_LO[VW-1:0];
		end else begin
			finish = sh[VW-1:0];
		end
	endfunction

	always_comb begin
		for (int n = 0; n < 6; n++) begin
			nx[n] = face.first_i ? cur[n] : nbr_x[n];
			ny[n] = face.first_j ? cur[n] : nbr_y[n];
			nz[n] = face.first_k ? cur[n] : nbr_z[n];
		end

		// E update: curl B minus current term
		acc[0] = lift(cur[0]) + AW'(term(coef_y, cur[5], ny[5]))
			+ AW'(term(coef_z, nz[4], cur[4])) + AW'(term(coef_current, '0, jv[0]));
		acc[1] = lift(cur[1]) + AW'(term(coef_z, cur[3], nz[3]))
			+ AW'(term(coef_x, nx[5], cur[5])) + AW'(term(coef_current, '0, jv[1]));
		acc[2] = lift(cur[2]) + AW'(term(coef_x, cur[4], nx[4]))
			+ AW'(term(coef_y, ny[3], cur[3])) + AW'(term(coef_current, '0, jv[2]));

		// B update: minus curl E
		acc[3] = lift(cur[3]) + AW'(term(coef_z, cur[1], nz[1]))
			+ AW'(term(coef_y, ny[2], cur[2]));
		acc[4] = lift(cur[4]) + AW'(term(coef_x, cur[2], nx[2]))
			+ AW'(term(coef_z, nz[0], cur[0]));
		acc[5] = lift(cur[5]) + AW'(term(coef_y, cur[0], ny[0]))
			+ AW'(term(coef_x, nx[1], cur[1]));

		for (int n = 0; n < 6; n++) begin
			res[n] = finish(acc[n]);
		end
	end

endmodule

[design/maxwell_field_stencil_update_top.sv]
// ----------------------------------------------------------------------------
// maxwell_field_stencil_update_top
// An accepted input passes the input register, then the result register, before
// result valid; one cell per cycle while out_stall is low, bounded by the loop from
// the result register (k-1 neighbor) through the curl update back into it.
// Reset clears valids and grid position and loads config defaults; row/plane RAMs are not cleared.
// ----------------------------------------------------------------------------
`include "maxwell_field_stencil_update_top_macros.svh"

module maxwell_field_stencil_update_top #(
	parameter int MAX_EDGE    = 32,
	parameter int VALUE_WIDTH = 32
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic signed [VALUE_WIDTH-1:0]      ex,
	input  logic signed [VALUE_WIDTH-1:0]      ey,
	input  logic signed [VALUE_WIDTH-1:0]      ez,
	input  logic signed [VALUE_WIDTH-1:0]      bx,
	input  logic signed [VALUE_WIDTH-1:0]      by,
	input  logic signed [VALUE_WIDTH-1:0]      bz,
	input  logic signed [VALUE_WIDTH-1:0]      jx,
	input  logic signed [VALUE_WIDTH-1:0]      jy,
	input  logic signed [VALUE_WIDTH-1:0]      jz,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic signed [VALUE_WIDTH-1:0]      new_ex,
	output logic signed [VALUE_WIDTH-1:0]      new_ey,
	output logic signed [VALUE_WIDTH-1:0]      new_ez,
	output logic signed [VALUE_WIDTH-1:0]      new_bx,
	output logic signed [VALUE_WIDTH-1:0]      new_by,
	output logic signed [VALUE_WIDTH-1:0]      new_bz,
	output logic                               sweep_end,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [mfsu_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [mfsu_pkg::COEF_W-1:0]        cfg_data
);

	localparam int VW  = VALUE_WIDTH;
	localparam int PW  = $clog2(MAX_EDGE);
	localparam int CW  = $clog2(MAX_EDGE + 1);
	localparam int PLD = MAX_EDGE * MAX_EDGE;
	localparam int PLW = $clog2(PLD);
	localparam int WW  = 6 * VW;

	// configuration
	logic [mfsu_pkg::EDGE_W-1:0]        grid_edge_q;
	logic signed [mfsu_pkg::COEF_W-1:0] coef_x_q;
	logic signed [mfsu_pkg::COEF_W-1:0] coef_y_q;
	logic signed [mfsu_pkg::COEF_W-1:0] coef_z_q;
	logic signed [mfsu_pkg::COEF_W-1:0] coef_current_q;

	// position
	logic [PW-1:0] pos_i_q, pos_j_q, pos_k_q;
	logic [CW-1:0] edge_eff;
	logic          last_i, last_j, last_k;
	logic          pos_in_range;

	// stage 1
	logic                  s1_valid;
	logic signed [VW-1:0]  cur_s1 [6];
	logic signed [VW-1:0]  jv_s1  [3];
	mfsu_pkg::face_t       face_s1;
	logic                  end_s1;
	logic [PW-1:0]         row_addr_s1;
	logic [PLW-1:0]        plane_addr_s1;

	// result / previous cell
	logic                  out_valid_q;
	logic signed [VW-1:0]  res_q [6];
	logic                  end_q;

	logic                  accept, advance;
	logic [PLW-1:0]        plane_addr;
	logic signed [VW-1:0]  res   [6];
	logic signed [VW-1:0]  nbr_x [6];
	logic signed [VW-1:0]  nbr_y [6];
	logic [WW-1:0]         wr_word, row_rdata, plane_rdata;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_edge_q    <= mfsu_pkg::GRID_EDGE_RST;
			coef_x_q       <= mfsu_pkg::COEF_AXIS_RST;
			coef_y_q       <= mfsu_pkg::COEF_AXIS_RST;
			coef_z_q       <= mfsu_pkg::COEF_AXIS_RST;
			coef_current_q <= mfsu_pkg::COEF_CURRENT_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				mfsu_pkg::CFG_GRID_EDGE:    grid_edge_q    <= cfg_data[mfsu_pkg::EDGE_W-1:0];
				mfsu_pkg::CFG_COEF_X:       coef_x_q       <= $signed(cfg_data);
				mfsu_pkg::CFG_COEF_Y:       coef_y_q       <= $signed(cfg_data);
				mfsu_pkg::CFG_COEF_Z:       coef_z_q       <= $signed(cfg_data);
				mfsu_pkg::CFG_COEF_CURRENT: coef_current_q <= $signed(cfg_data);
				default: begin
				end
			endcase
		end
	end

	// effective edge: zero reads as one, clamp to MAX_EDGE
	always_comb begin
		if ({1'b0, grid_edge_q} > 7'(MAX_EDGE)) begin
			edge_eff = CW'(MAX_EDGE);
		end else if (grid_edge_q == '0) begin
			edge_eff = CW'(1);
		end else begin
			edge_eff = CW'(grid_edge_q);
		end
	end

	assign last_k = (CW'(pos_k_q) + CW'(1)) >= edge_eff;
	assign last_j = (CW'(pos_j_q) + CW'(1)) >= edge_eff;
	assign last_i = (CW'(pos_i_q) + CW'(1)) >= edge_eff;

	assign pos_in_range = (CW'(pos_i_q) < CW'(MAX_EDGE)) && (CW'(pos_j_q) < CW'(MAX_EDGE))
		&& (CW'(pos_k_q) < CW'(MAX_EDGE));

	assign plane_addr = PLW'(pos_j_q) * PLW'(MAX_EDGE) + PLW'(pos_k_q);

	assign advance  = s1_valid && (!out_valid_q || !out_stall);
	assign in_stall = s1_valid && !advance;
	assign accept   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_i_q <= '0;
			pos_j_q <= '0;
			pos_k_q <= '0;
		end else if (accept) begin
			if (last_k) begin
				pos_k_q <= '0;
				if (last_j) begin
					pos_j_q <= '0;
					pos_i_q <= last_i ? '0 : pos_i_q + PW'(1);
				end else begin
					pos_j_q <= pos_j_q + PW'(1);
				end
			end else begin
				pos_k_q <= pos_k_q + PW'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				s1_valid <= 1'b1;
			end else if (advance) begin
				s1_valid <= 1'b0;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cur_s1[0]     <= ex;
			cur_s1[1]     <= ey;
			cur_s1[2]     <= ez;
			cur_s1[3]     <= bx;
			cur_s1[4]     <= by;
			cur_s1[5]     <= bz;
			jv_s1[0]      <= jx;
			jv_s1[1]      <= jy;
			jv_s1[2]      <= jz;
			face_s1       <= '{first_i: pos_i_q == '0, first_j: pos_j_q == '0,
				first_k: pos_k_q == '0};
			end_s1        <= last_k && last_j && last_i;
			row_addr_s1   <= pos_k_q;
			plane_addr_s1 <= plane_addr;
		end
		if (advance) begin
			res_q <= res;
			end_q <= end_s1;
		end
	end

	always_comb begin
		for (int n = 0; n < 6; n++) begin
			wr_word[n*VW +: VW] = res[n];
			nbr_y[n]            = $signed(row_rdata[n*VW +: VW]);
			nbr_x[n]            = $signed(plane_rdata[n*VW +: VW]);
		end
	end

	mfsu_ram #(
		.WIDTH (WW),
		.DEPTH (MAX_EDGE)
	) u_row_ram (
		.clk     (clk),
		.wr_en   (advance),
		.wr_addr (row_addr_s1),
		.wr_data (wr_word),
		.rd_en   (accept),
		.rd_addr (pos_k_q),
		.rd_data (row_rdata)
	);

	mfsu_ram #(
		.WIDTH (WW),
		.DEPTH (PLD)
	) u_plane_ram (
		.clk     (clk),
		.wr_en   (advance),
		.wr_addr (plane_addr_s1),
		.wr_data (wr_word),
		.rd_en   (accept),
		.rd_addr (plane_addr),
		.rd_data (plane_rdata)
	);

	mfsu_calc #(
		.VALUE_WIDTH (VW)
	) u_calc (
		.cur          (cur_s1),
		.jv           (jv_s1),
		.nbr_x        (nbr_x),
		.nbr_y        (nbr_y),
		.nbr_z        (res_q),
		.coef_x       (coef_x_q),
		.coef_y       (coef_y_q),
		.coef_z       (coef_z_q),
		.coef_current (coef_current_q),
		.face         (face_s1),
		.res          (res)
	);

	assign out_valid = out_valid_q;
	assign new_ex    = res_q[0];
	assign new_ey    = res_q[1];
	assign new_ez    = res_q[2];
	assign new_bx    = res_q[3];
	assign new_by    = res_q[4];
	assign new_bz    = res_q[5];
	assign sweep_end = end_q;

	`MFSU_ASSERT_NEXT(a_s1_held, clk, arst_n, s1_valid && !advance, s1_valid)
	`MFSU_ASSERT_NEXT(a_adv_to_out, clk, arst_n, advance, out_valid_q)
	`MFSU_ASSERT_IMPL(a_pos_range, clk, arst_n, 1'b1, pos_in_range)

endmodule
